@@ hdl/clt_pkg.sv @@
package clt_pkg;

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_BANG       = 8'h21;
   localparam logic [7:0] CHAR_TILDE      = 8'h7E;
   localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE     = 8'h27;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_WORD,
      PH_GAP,
      PH_QUOTED,
      PH_ARG,
      PH_TRAIL,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_BADWORD = 2'd2,
      ST_BADFMT  = 2'd3
   } status_type;

   typedef struct packed {
      logic is_zero;
      logic is_space;
      logic is_word;
      logic is_graph;
      logic is_quote;
   } char_class_type;

   typedef struct packed {
      logic       hit;
      status_type verdict;
   } finish_type;

   // Verdict given when the string ends in the given phase.
   function automatic finish_type end_string(input phase_type ph);
      finish_type f;
      f.hit     = 1'b1;
      f.verdict = ST_OK;
      unique case (ph)
         PH_LEAD:                   f.verdict = ST_EMPTY;
         PH_WORD, PH_QUOTED:        f.verdict = ST_BADFMT;
         PH_GAP, PH_ARG, PH_TRAIL:  f.verdict = ST_OK;
         default:                   f.hit     = 1'b0;
      endcase
      return f;
   endfunction

endpackage

@@ hdl/clt_char_class.sv @@
module clt_char_class
   import clt_pkg::*;
(
   input  logic [7:0]     char_byte,
   output char_class_type char_class
);

   always_comb begin
      char_class.is_zero  = (char_byte == CHAR_NUL);
      char_class.is_space = (char_byte == CHAR_SPACE) ||
                            (char_byte >= CHAR_TAB && char_byte <= CHAR_CR);
      char_class.is_word  = (char_byte >= CHAR_DIGIT_0 && char_byte <= CHAR_DIGIT_9) ||
                            (char_byte >= CHAR_UPPER_A && char_byte <= CHAR_UPPER_Z) ||
                            (char_byte >= CHAR_LOWER_A && char_byte <= CHAR_LOWER_Z) ||
                            (char_byte == CHAR_UNDERSCORE);
      char_class.is_graph = (char_byte >= CHAR_BANG && char_byte <= CHAR_TILDE);
      char_class.is_quote = (char_byte == CHAR_DQUOTE) || (char_byte == CHAR_SQUOTE);
   end

endmodule

@@ hdl/command_line_tokenizer.sv @@
// Splits a command line, one byte per input beat, into a command word and an
// optional plain or quoted argument. A new beat is accepted in every cycle,
// even while a result waits in the output register, as long as that register
// is empty or being emptied; the whole phase update is one pass of logic
// between the tokenizer state and the result register. One result beat is
// produced for the beat marked by req_tlast; it is registered and appears in
// the cycle after that beat is accepted, and the state then starts afresh for
// the next line. Offsets and lengths are reported in their low eight bits;
// a byte at offset LINE_MAX or more marks a still open line as badly formatted.
module command_line_tokenizer
   import clt_pkg::*;
#(
   parameter int LINE_MAX = 256
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // char_byte
   input  logic                  req_tlast,  // line_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status, word_start, word_len,
                                             // arg_present, arg_start, arg_len
);

   localparam int POS_W = $clog2(LINE_MAX + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_MAX);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [POS_W-1:0] word_begin_ff, word_begin_in;
   logic [POS_W-1:0] word_length_ff, word_length_in;
   logic [POS_W-1:0] arg_begin_ff, arg_begin_in;
   logic [POS_W-1:0] arg_length_ff, arg_length_in;
   logic [7:0]       open_quote_ff, open_quote_in;
   status_type       verdict_ff, verdict_in;
   logic             arg_found_ff, arg_found_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   char_class_type char_class;
   finish_type     fin_zero;
   finish_type     fin_end;
   logic           req_beat;
   status_type     out_status;

   clt_char_class u_char_class (
      .char_byte  (req_tdata),
      .char_class (char_class)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign fin_zero = end_string(phase_ff);

   always_comb begin
      phase_in       = phase_ff;
      position_in    = position_ff;
      word_begin_in  = word_begin_ff;
      word_length_in = word_length_ff;
      arg_begin_in   = arg_begin_ff;
      arg_length_in  = arg_length_ff;
      open_quote_in  = open_quote_ff;
      verdict_in     = verdict_ff;
      arg_found_in   = arg_found_ff;

      if (phase_ff != PH_DONE) begin
         if (position_ff >= POS_LIMIT) begin
            phase_in   = PH_DONE;
            verdict_in = ST_BADFMT;
         end else if (char_class.is_zero) begin
            if (fin_zero.hit) begin
               phase_in   = PH_DONE;
               verdict_in = fin_zero.verdict;
            end
         end else begin
            unique case (phase_ff)
               PH_LEAD: begin
                  if (char_class.is_space) begin
                     phase_in = PH_LEAD;
                  end else if (char_class.is_word) begin
                     word_begin_in  = position_ff;
                     word_length_in = POS_W'(1);
                     phase_in       = PH_WORD;
                  end else begin
                     phase_in   = PH_DONE;
                     verdict_in = ST_BADWORD;
                  end
               end
               PH_WORD: begin
                  if (char_class.is_word) begin
                     word_length_in = word_length_ff + POS_W'(1);
                  end else if (char_class.is_space) begin
                     phase_in = PH_GAP;
                  end else begin
                     phase_in   = PH_DONE;
                     verdict_in = ST_BADFMT;
                  end
               end
               PH_GAP: begin
                  if (char_class.is_space) begin
                     phase_in = PH_GAP;
                  end else if (char_class.is_quote) begin
                     open_quote_in = req_tdata;
                     arg_begin_in  = position_ff + POS_W'(1);
                     arg_length_in = '0;
                     arg_found_in  = 1'b1;
                     phase_in      = PH_QUOTED;
                  end else if (char_class.is_graph) begin
                     arg_begin_in  = position_ff;
                     arg_length_in = POS_W'(1);
                     arg_found_in  = 1'b1;
                     phase_in      = PH_ARG;
                  end else begin
                     phase_in   = PH_DONE;
                     verdict_in = ST_OK;
                  end
               end
               PH_QUOTED: begin
                  if (req_tdata == open_quote_ff) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     arg_length_in = arg_length_ff + POS_W'(1);
                  end
               end
               PH_ARG: begin
                  if (char_class.is_graph) begin
                     arg_length_in = arg_length_ff + POS_W'(1);
                  end else if (char_class.is_space) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in   = PH_DONE;
                     verdict_in = ST_BADFMT;
                  end
               end
               PH_TRAIL: begin
                  if (!char_class.is_space) begin
                     phase_in   = PH_DONE;
                     verdict_in = ST_BADFMT;
                  end
               end
               default: begin
                  phase_in   = PH_DONE;
                  verdict_in = ST_BADFMT;
               end
            endcase
         end
      end

      if (position_ff < POS_LIMIT) begin
         position_in = position_ff + POS_W'(1);
      end
   end

   // The end of the line closes the string unless it has already ended.
   assign fin_end    = end_string(phase_in);
   assign out_status = fin_end.hit ? fin_end.verdict : verdict_in;

   always_comb begin
      rsp_data_in      = '0;
      rsp_data_in[1:0] = out_status;
      if (out_status == ST_OK) begin
         rsp_data_in[9:2]   = 8'(word_begin_in);
         rsp_data_in[17:10] = 8'(word_length_in);
         if (arg_found_in) begin
            rsp_data_in[18]    = 1'b1;
            rsp_data_in[26:19] = 8'(arg_begin_in);
            rsp_data_in[34:27] = 8'(arg_length_in);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEAD;
         position_ff    <= '0;
         word_begin_ff  <= '0;
         word_length_ff <= '0;
         arg_begin_ff   <= '0;
         arg_length_ff  <= '0;
         open_quote_ff  <= '0;
         verdict_ff     <= ST_OK;
         arg_found_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_beat) begin
            if (req_tlast) begin
               phase_ff       <= PH_LEAD;
               position_ff    <= '0;
               word_begin_ff  <= '0;
               word_length_ff <= '0;
               arg_begin_ff   <= '0;
               arg_length_ff  <= '0;
               open_quote_ff  <= '0;
               verdict_ff     <= ST_OK;
               arg_found_ff   <= 1'b0;
            end else begin
               phase_ff       <= phase_in;
               position_ff    <= position_in;
               word_begin_ff  <= word_begin_in;
               word_length_ff <= word_length_in;
               arg_begin_ff   <= arg_begin_in;
               arg_length_ff  <= arg_length_in;
               open_quote_ff  <= open_quote_in;
               verdict_ff     <= verdict_in;
               arg_found_ff   <= arg_found_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tlast |=> rsp_tvalid)
      else $error("line end beat did not produce a result");

   a_bad_status_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1:0] != ST_OK |-> rsp_data_ff[34:2] == '0)
      else $error("fields set on a result without ok status");

   a_no_arg_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[18] |-> rsp_data_ff[34:19] == '0)
      else $error("argument fields set without an argument");

   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_LIMIT && word_length_ff <= POS_LIMIT)
      else $error("position or word length beyond the line limit");
`endif

endmodule
